### rtl/core/ptsc_pkg.sv
// Shared types, register indexes and fixed-point constants for the pan/tilt
// tracking servo controller. No dependencies.
package ptsc_pkg;

    // request codes
    localparam logic [1:0] REQ_TRACK  = 2'd0;
    localparam logic [1:0] REQ_ABS    = 2'd1;
    localparam logic [1:0] REQ_CENTER = 2'd2;

    // configuration register indexes
    localparam logic [2:0] CFG_INVERT       = 3'd0;
    localparam logic [2:0] CFG_GAIN_YAW     = 3'd1;
    localparam logic [2:0] CFG_GAIN_PITCH   = 3'd2;
    localparam logic [2:0] CFG_SMOOTH_YAW   = 3'd3;
    localparam logic [2:0] CFG_SMOOTH_PITCH = 3'd4;
    localparam logic [2:0] CFG_DEADZONE     = 3'd5;
    localparam logic [2:0] CFG_TRIM_YAW     = 3'd6;
    localparam logic [2:0] CFG_TRIM_PITCH   = 3'd7;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 32;

    localparam logic [15:0] GAIN_RESET = 16'd819;
    localparam logic [16:0] SMOOTH_ONE = 17'h10000;

    // default axis limits, Q8.8 degrees, and pulse limits in us
    localparam int YAW_MIN_ANGLE_DEF   = -23040;
    localparam int YAW_MAX_ANGLE_DEF   = 23040;
    localparam int PITCH_MIN_ANGLE_DEF = -23040;
    localparam int PITCH_MAX_ANGLE_DEF = 23040;
    localparam int PULSE_MIN_US_DEF    = 500;
    localparam int PULSE_MAX_US_DEF    = 2500;

    // 90 and 180 degrees in Q8.8, final pulse clip
    localparam int ANGLE_OFFSET  = 23040;
    localparam int ANGLE_SPAN    = 46080;
    localparam int PULSE_CLIP_LO = 500;
    localparam int PULSE_CLIP_HI = 2500;

    // serial arithmetic widths
    localparam int MUL_A_W   = 17;
    localparam int MUL_B_W   = 17;
    localparam int PROD_W    = MUL_A_W + MUL_B_W + 1;
    localparam int DIV_NUM_W = 27;   // |span * a| is at most 2000 * 46080
    localparam int DIV_Q_W   = 11;   // quotient stays below 2048

    typedef struct packed {
        logic [1:0]         req_type;
        logic signed [15:0] err_x;
        logic signed [15:0] err_y;
        logic signed [15:0] abs_yaw;
        logic signed [15:0] abs_pitch;
    } in_item_t;

    typedef struct packed {
        logic [11:0]        yaw_pulse_us;
        logic [11:0]        pitch_pulse_us;
        logic signed [15:0] yaw_angle;
        logic signed [15:0] pitch_angle;
    } out_item_t;

    typedef struct packed {
        logic               inv;
        logic [15:0]        gain;
        logic [16:0]        smooth;
        logic [15:0]        dz;
        logic signed [15:0] trim;
    } axis_cfg_t;

    typedef struct packed {
        logic               done;
        logic [11:0]        pulse;
        logic signed [15:0] angle;
    } axis_stat_t;

endpackage

### rtl/core/ptsc_mul.sv
// Bit-serial signed-by-unsigned multiplier, one multiplier bit per cycle.
// Depends on nothing but its parameters.
module ptsc_mul #(
    parameter int A_W = 17,
    parameter int B_W = 17
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   start,
    input  logic signed [A_W-1:0]  a,
    input  logic [B_W-1:0]         b,
    output logic                   done,
    output logic signed [A_W+B_W:0] prod
);

    localparam int CNT_W = (B_W > 1) ? $clog2(B_W) : 1;

    logic signed [A_W-1:0] a_reg;
    logic signed [A_W:0]   hi_reg, hi_next;
    logic [B_W-1:0]        lo_reg, lo_next;
    logic [CNT_W-1:0]      cnt_reg;
    logic                  run_reg;
    logic                  done_reg;
    logic signed [A_W+1:0] addend;
    logic signed [A_W+1:0] acc;

    always_comb begin
        addend  = lo_reg[0] ? {{2{a_reg[A_W-1]}}, a_reg} : '0;
        acc     = {hi_reg[A_W], hi_reg} + addend;
        // shift right: product bit drops into the low half
        hi_next = acc[A_W+1:1];
        lo_next = {acc[0], lo_reg[B_W-1:1]};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                a_reg   <= a;
                hi_reg  <= '0;
                lo_reg  <= b;
                cnt_reg <= '0;
                run_reg <= 1'b1;
            end else if (run_reg) begin
                hi_reg  <= hi_next;
                lo_reg  <= lo_next;
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(B_W - 1)) begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done = done_reg;
    assign prod = {hi_reg, lo_reg};

endmodule

### rtl/core/ptsc_div.sv
// Restoring divider by a fixed divisor, one quotient bit per cycle.
// Depends on nothing but its parameters.
module ptsc_div #(
    parameter int N_W     = 27,
    parameter int Q_W     = 11,
    parameter int DIVISOR = 46080
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           start,
    input  logic [N_W-1:0] num,
    output logic           done,
    output logic [Q_W-1:0] quo
);

    localparam int CNT_W = (Q_W > 1) ? $clog2(Q_W) : 1;
    localparam logic [N_W-1:0] DV_INIT = N_W'(DIVISOR) << (Q_W - 1);

    logic [N_W-1:0]   rem_reg;
    logic [N_W-1:0]   dv_reg;
    logic [Q_W-1:0]   quo_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             run_reg;
    logic             done_reg;
    logic             fits;

    assign fits = (rem_reg >= dv_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                rem_reg <= num;
                dv_reg  <= DV_INIT;
                quo_reg <= '0;
                cnt_reg <= '0;
                run_reg <= 1'b1;
            end else if (run_reg) begin
                if (fits) begin
                    rem_reg <= rem_reg - dv_reg;
                end
                quo_reg <= {quo_reg[Q_W-2:0], fits};
                dv_reg  <= dv_reg >> 1;
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(Q_W - 1)) begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done = done_reg;
    assign quo  = quo_reg;

endmodule

### rtl/core/ptsc_axis.sv
// One servo axis: held angle, tracking step, smoothing and pulse mapping.
// Depends on ptsc_pkg, ptsc_mul and ptsc_div.
module ptsc_axis #(
    parameter int MIN_ANGLE = ptsc_pkg::YAW_MIN_ANGLE_DEF,
    parameter int MAX_ANGLE = ptsc_pkg::YAW_MAX_ANGLE_DEF,
    parameter int PULSE_MIN = ptsc_pkg::PULSE_MIN_US_DEF,
    parameter int PULSE_MAX = ptsc_pkg::PULSE_MAX_US_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 start,
    input  logic [1:0]           req_type,
    input  logic signed [15:0]   err,
    input  logic signed [15:0]   abs_angle,
    input  ptsc_pkg::axis_cfg_t  cfg,
    input  logic                 ack,
    output ptsc_pkg::axis_stat_t stat
);

    localparam int PW = ptsc_pkg::PROD_W;

    localparam logic signed [23:0] LO24  = 24'(MIN_ANGLE);
    localparam logic signed [23:0] HI24  = 24'(MAX_ANGLE);
    localparam logic signed [15:0] LO16  = 16'(MIN_ANGLE);
    localparam logic signed [15:0] HI16  = 16'(MAX_ANGLE);
    localparam logic signed [16:0] SPAN  = 17'(PULSE_MAX - PULSE_MIN);
    localparam logic signed [12:0] PMIN  = 13'(PULSE_MIN);
    localparam logic signed [12:0] CLIPL = 13'(ptsc_pkg::PULSE_CLIP_LO);
    localparam logic signed [12:0] CLIPH = 13'(ptsc_pkg::PULSE_CLIP_HI);
    localparam logic signed [17:0] OFS   = 18'(ptsc_pkg::ANGLE_OFFSET);
    localparam logic signed [17:0] ASPAN = 18'(ptsc_pkg::ANGLE_SPAN);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_GAIN,
        ST_SMOOTH,
        ST_PSET,
        ST_PMUL,
        ST_PDIV,
        ST_DONE
    } state_t;

    state_t state_reg;

    logic signed [15:0] held_reg;
    logic [11:0]        pulse_reg;
    logic               neg_reg;

    logic                                 mul_start_reg;
    logic signed [ptsc_pkg::MUL_A_W-1:0]  mul_a_reg;
    logic [ptsc_pkg::MUL_B_W-1:0]         mul_b_reg;
    logic                                 mul_done;
    logic signed [PW-1:0]                 mul_prod;

    logic                                 div_start_reg;
    logic [ptsc_pkg::DIV_NUM_W-1:0]       div_num_reg;
    logic                                 div_done;
    logic [ptsc_pkg::DIV_Q_W-1:0]         div_quo;

    logic signed [16:0] err_ext, e_val, e_dz;
    logic [16:0]        e_mag;
    logic [16:0]        smooth_sat;
    logic signed [PW-1:0] rnd_step, rnd_smooth, p_mag;
    logic signed [23:0] step, sum24;
    logic signed [15:0] target;
    logic signed [16:0] diff;
    logic signed [17:0] delta, held_sum;
    logic signed [15:0] held_track, held_abs;
    logic signed [17:0] asum;
    logic [15:0]        a_clamp;
    logic signed [12:0] q_signed, pval;
    logic [11:0]        pulse_clip;

    always_comb begin
        // error after inversion and deadzone
        err_ext = {err[15], err};
        e_val   = cfg.inv ? -err_ext : err_ext;
        e_mag   = e_val[16] ? 17'(-e_val) : 17'(e_val);
        e_dz    = (e_mag <= {1'b0, cfg.dz}) ? '0 : e_val;

        smooth_sat = cfg.smooth[16] ? ptsc_pkg::SMOOTH_ONE : cfg.smooth;

        // proportional step, rounded from Q.18 to Q8.8, and clamped target
        rnd_step = mul_prod + PW'(512);
        step     = rnd_step[33:10];
        sum24    = {{8{held_reg[15]}}, held_reg} + step;
        if (sum24 < LO24) begin
            target = LO16;
        end else if (sum24 > HI24) begin
            target = HI16;
        end else begin
            target = sum24[15:0];
        end
        diff = {target[15], target} - {held_reg[15], held_reg};

        // smoothing update, rounded from Q.16
        rnd_smooth = mul_prod + PW'(32768);
        delta      = rnd_smooth[33:16];
        held_sum   = {{2{held_reg[15]}}, held_reg} + delta;
        held_track = held_sum[15:0];

        if (abs_angle < LO16) begin
            held_abs = LO16;
        end else if (abs_angle > HI16) begin
            held_abs = HI16;
        end else begin
            held_abs = abs_angle;
        end

        // angle plus trim, offset by 90 degrees, clamped to 0..180
        asum = {{2{held_reg[15]}}, held_reg} + {{2{cfg.trim[15]}}, cfg.trim} + OFS;
        if (asum < 18'sd0) begin
            a_clamp = '0;
        end else if (asum > ASPAN) begin
            a_clamp = ASPAN[15:0];
        end else begin
            a_clamp = asum[15:0];
        end

        p_mag = mul_prod[PW-1] ? -mul_prod : mul_prod;

        // quotient truncates toward zero: divide the magnitude, restore the sign
        q_signed = neg_reg ? -$signed({2'b00, div_quo}) : $signed({2'b00, div_quo});
        pval     = PMIN + q_signed;
        if (pval < CLIPL) begin
            pulse_clip = CLIPL[11:0];
        end else if (pval > CLIPH) begin
            pulse_clip = CLIPH[11:0];
        end else begin
            pulse_clip = pval[11:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            held_reg      <= '0;
            mul_start_reg <= 1'b0;
            div_start_reg <= 1'b0;
        end else begin
            mul_start_reg <= 1'b0;
            div_start_reg <= 1'b0;
            case (state_reg)
                ST_IDLE: begin
                    if (start) begin
                        case (req_type)
                            ptsc_pkg::REQ_TRACK: begin
                                mul_a_reg     <= e_dz;
                                mul_b_reg     <= {1'b0, cfg.gain};
                                mul_start_reg <= 1'b1;
                                state_reg     <= ST_GAIN;
                            end
                            ptsc_pkg::REQ_ABS: begin
                                held_reg  <= held_abs;
                                state_reg <= ST_PSET;
                            end
                            ptsc_pkg::REQ_CENTER: begin
                                held_reg  <= '0;
                                state_reg <= ST_PSET;
                            end
                            default: begin
                                state_reg <= ST_PSET;
                            end
                        endcase
                    end
                end
                ST_GAIN: begin
                    if (mul_done) begin
                        mul_a_reg     <= diff;
                        mul_b_reg     <= smooth_sat;
                        mul_start_reg <= 1'b1;
                        state_reg     <= ST_SMOOTH;
                    end
                end
                ST_SMOOTH: begin
                    if (mul_done) begin
                        held_reg  <= held_track;
                        state_reg <= ST_PSET;
                    end
                end
                ST_PSET: begin
                    mul_a_reg     <= SPAN;
                    mul_b_reg     <= {1'b0, a_clamp};
                    mul_start_reg <= 1'b1;
                    state_reg     <= ST_PMUL;
                end
                ST_PMUL: begin
                    if (mul_done) begin
                        neg_reg       <= mul_prod[PW-1];
                        div_num_reg   <= p_mag[ptsc_pkg::DIV_NUM_W-1:0];
                        div_start_reg <= 1'b1;
                        state_reg     <= ST_PDIV;
                    end
                end
                ST_PDIV: begin
                    if (div_done) begin
                        pulse_reg <= pulse_clip;
                        state_reg <= ST_DONE;
                    end
                end
                ST_DONE: begin
                    if (ack) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    ptsc_mul #(
        .A_W (ptsc_pkg::MUL_A_W),
        .B_W (ptsc_pkg::MUL_B_W)
    ) u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mul_start_reg),
        .a       (mul_a_reg),
        .b       (mul_b_reg),
        .done    (mul_done),
        .prod    (mul_prod)
    );

    ptsc_div #(
        .N_W     (ptsc_pkg::DIV_NUM_W),
        .Q_W     (ptsc_pkg::DIV_Q_W),
        .DIVISOR (ptsc_pkg::ANGLE_SPAN)
    ) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start_reg),
        .num     (div_num_reg),
        .done    (div_done),
        .quo     (div_quo)
    );

    always_comb begin
        stat.done  = (state_reg == ST_DONE);
        stat.pulse = pulse_reg;
        stat.angle = held_reg;
    end

endmodule

### rtl/core/pan_tilt_tracking_servo_control.sv
// Pan/tilt servo controller top: handshake, config registers, two axes, result
// register. Depends on ptsc_pkg and ptsc_axis.
// A tracking request runs three serial multiplies and one serial divide in each axis,
// other requests one multiply and one divide. A new request is taken only once the last
// result has gone into the result register, and the next request is taken while that result
// waits. Reset (aresetn low, sync) zeroes angles, loads defaults.
module pan_tilt_tracking_servo_control #(
    parameter int YAW_MIN_ANGLE   = ptsc_pkg::YAW_MIN_ANGLE_DEF,
    parameter int YAW_MAX_ANGLE   = ptsc_pkg::YAW_MAX_ANGLE_DEF,
    parameter int PITCH_MIN_ANGLE = ptsc_pkg::PITCH_MIN_ANGLE_DEF,
    parameter int PITCH_MAX_ANGLE = ptsc_pkg::PITCH_MAX_ANGLE_DEF,
    parameter int PULSE_MIN_US    = ptsc_pkg::PULSE_MIN_US_DEF,
    parameter int PULSE_MAX_US    = ptsc_pkg::PULSE_MAX_US_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  ptsc_pkg::in_item_t                  s_payload,
    output logic                                m_valid,
    input  logic                                m_ready,
    output ptsc_pkg::out_item_t                 m_payload,
    input  logic                                cfg_we,
    input  logic [ptsc_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [ptsc_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } state_t;

    state_t state_reg;

    ptsc_pkg::in_item_t  item_reg;
    ptsc_pkg::out_item_t out_reg;
    logic                out_valid_reg;
    logic                start_reg;

    logic [1:0]         invert_reg;
    logic [15:0]        gain_yaw_reg, gain_pitch_reg;
    logic [16:0]        smooth_yaw_reg, smooth_pitch_reg;
    logic [31:0]        deadzone_reg;
    logic signed [15:0] trim_yaw_reg, trim_pitch_reg;

    ptsc_pkg::axis_cfg_t  yaw_cfg, pitch_cfg;
    ptsc_pkg::axis_stat_t yaw_stat, pitch_stat;

    logic accept;
    logic out_free;
    logic ack;

    assign s_ready  = (state_reg == ST_IDLE);
    assign accept   = s_valid && s_ready;
    assign out_free = !out_valid_reg || m_ready;
    assign ack      = (state_reg == ST_RUN) && yaw_stat.done && pitch_stat.done && out_free;

    always_comb begin
        yaw_cfg.inv      = invert_reg[0];
        yaw_cfg.gain     = gain_yaw_reg;
        yaw_cfg.smooth   = smooth_yaw_reg;
        yaw_cfg.dz       = deadzone_reg[15:0];
        yaw_cfg.trim     = trim_yaw_reg;
        pitch_cfg.inv    = invert_reg[1];
        pitch_cfg.gain   = gain_pitch_reg;
        pitch_cfg.smooth = smooth_pitch_reg;
        pitch_cfg.dz     = deadzone_reg[31:16];
        pitch_cfg.trim   = trim_pitch_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            invert_reg       <= '0;
            gain_yaw_reg     <= ptsc_pkg::GAIN_RESET;
            gain_pitch_reg   <= ptsc_pkg::GAIN_RESET;
            smooth_yaw_reg   <= ptsc_pkg::SMOOTH_ONE;
            smooth_pitch_reg <= ptsc_pkg::SMOOTH_ONE;
            deadzone_reg     <= '0;
            trim_yaw_reg     <= '0;
            trim_pitch_reg   <= '0;
        end else if (cfg_we) begin
            case (cfg_index)
                ptsc_pkg::CFG_INVERT:       invert_reg       <= cfg_wdata[1:0];
                ptsc_pkg::CFG_GAIN_YAW:     gain_yaw_reg     <= cfg_wdata[15:0];
                ptsc_pkg::CFG_GAIN_PITCH:   gain_pitch_reg   <= cfg_wdata[15:0];
                ptsc_pkg::CFG_SMOOTH_YAW:   smooth_yaw_reg   <= cfg_wdata[16:0];
                ptsc_pkg::CFG_SMOOTH_PITCH: smooth_pitch_reg <= cfg_wdata[16:0];
                ptsc_pkg::CFG_DEADZONE:     deadzone_reg     <= cfg_wdata[31:0];
                ptsc_pkg::CFG_TRIM_YAW:     trim_yaw_reg     <= cfg_wdata[15:0];
                ptsc_pkg::CFG_TRIM_PITCH:   trim_pitch_reg   <= cfg_wdata[15:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            start_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            start_reg <= 1'b0;
            if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (accept) begin
                        item_reg  <= s_payload;
                        start_reg <= 1'b1;
                        state_reg <= ST_RUN;
                    end
                end
                ST_RUN: begin
                    // hold the finished request until the result register frees up
                    if (ack) begin
                        out_reg.yaw_pulse_us   <= yaw_stat.pulse;
                        out_reg.pitch_pulse_us <= pitch_stat.pulse;
                        out_reg.yaw_angle      <= yaw_stat.angle;
                        out_reg.pitch_angle    <= pitch_stat.angle;
                        out_valid_reg          <= 1'b1;
                        state_reg              <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_valid   = out_valid_reg;
    assign m_payload = out_reg;

    ptsc_axis #(
        .MIN_ANGLE (YAW_MIN_ANGLE),
        .MAX_ANGLE (YAW_MAX_ANGLE),
        .PULSE_MIN (PULSE_MIN_US),
        .PULSE_MAX (PULSE_MAX_US)
    ) u_yaw (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (start_reg),
        .req_type  (item_reg.req_type),
        .err       (item_reg.err_x),
        .abs_angle (item_reg.abs_yaw),
        .cfg       (yaw_cfg),
        .ack       (ack),
        .stat      (yaw_stat)
    );

    ptsc_axis #(
        .MIN_ANGLE (PITCH_MIN_ANGLE),
        .MAX_ANGLE (PITCH_MAX_ANGLE),
        .PULSE_MIN (PULSE_MIN_US),
        .PULSE_MAX (PULSE_MAX_US)
    ) u_pitch (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (start_reg),
        .req_type  (item_reg.req_type),
        .err       (item_reg.err_y),
        .abs_angle (item_reg.abs_pitch),
        .cfg       (pitch_cfg),
        .ack       (ack),
        .stat      (pitch_stat)
    );

endmodule
